// ----- hw/rtl/bavg_pkg.sv -----
// Shared types, constants and the character ramp for the block-average
// ASCII converter. No dependencies.
package bavg_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 20;
    localparam int CHAR_W     = 7;
    localparam int NPIX_W     = 13;
    localparam int BLK_W      = 7;
    localparam int TILE_W     = 6;
    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int CFG_W      = 13;
    localparam int WCFG_W     = 11;
    localparam int MAX_BLOCK  = 64;
    localparam int MAX_HEIGHT = 4096;
    localparam int RAMP_LENGTH = 70;
    localparam int IDX_W      = 7;
    localparam int PROD_W     = 15;
    localparam int FULL_SCALE = 255;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;

    // dark to light; the grave accent is written as octal 140
    localparam bit [8*RAMP_LENGTH-1:0] RAMP_STR =
        "$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:,\"^\140'. ";

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_IDX,
        ST_OUT1,
        ST_OUT2
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [CHAR_W-1:0] ramp_char(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = RAMP_STR[8*(RAMP_LENGTH-1-int'(idx)) +: 8];
        return b[CHAR_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/bavg_sum_mem.sv -----
// Tile sum storage: one entry per block column, synchronous registered
// read. Depends on bavg_pkg.
module bavg_sum_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [bavg_pkg::SUM_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [bavg_pkg::SUM_W-1:0] wr_data
);

    logic [bavg_pkg::SUM_W-1:0] mem [DEPTH];
    logic [bavg_pkg::SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bavg_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the tile mean.
// Depends on bavg_pkg.
module bavg_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bavg_pkg::SUM_W-1:0]  dividend,
    input  logic [bavg_pkg::NPIX_W-1:0] divisor,
    output logic [bavg_pkg::SUM_W-1:0]  quotient,
    output bavg_pkg::div_status_t       status
);

    localparam int CNT_W = $clog2(bavg_pkg::SUM_W + 1);

    logic [bavg_pkg::NPIX_W-1:0] rem_reg, rem_next;
    logic [bavg_pkg::SUM_W-1:0]  quo_reg, quo_next;
    logic [bavg_pkg::NPIX_W-1:0] dvs_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [bavg_pkg::NPIX_W:0]   shifted;
    logic [bavg_pkg::NPIX_W:0]   diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[bavg_pkg::SUM_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cnt_reg != '0) begin
            if (!diff[bavg_pkg::NPIX_W]) begin
                rem_next = diff[bavg_pkg::NPIX_W-1:0];
            end else begin
                rem_next = shifted[bavg_pkg::NPIX_W-1:0];
            end
            quo_next  = {quo_reg[bavg_pkg::SUM_W-2:0], ~diff[bavg_pkg::NPIX_W]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(bavg_pkg::SUM_W);
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

// ----- hw/rtl/block_average_to_ascii_ramp.sv -----
// Top level of the block-average ASCII converter: position counters,
// control sequencer and ramp lookup. Depends on bavg_pkg, bavg_sum_mem,
// bavg_divider.
//
// Usage: grayscale pixels enter on s_valid/s_ready in raster order. Each
// completed tile (block_size square, clipped at the right and bottom edges)
// yields two transfers on m_valid/m_ready carrying the same char_code; the
// second has second_copy set, plus line_end on the last tile of a row and
// frame_end on the last tile of the image.
// Sequencing: one pixel is handled at a time. A pixel that does not close a
// tile goes through a memory read, then an add and write back. A pixel that
// closes a tile goes through the same read and add, the one-bit-per-cycle
// mean divider and ramp mapping, then the two output transfers; s_ready
// stays low until the second copy is taken.
// A stalled receiver simply holds the block in its output states.
// Configuration writes (cfg_valid/cfg_ready, always ready) to addresses 0-2
// set a register and restart the frame. Reset restores 640x480 with 8-pixel
// tiles and zeroes all counters; the sum memory needs no clearing.
module block_average_to_ascii_ramp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_addr,
    input  logic [bavg_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bavg_pkg::PIX_W-1:0]    s_pixel_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bavg_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_second_copy,
    output logic                          m_line_end,
    output logic                          m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);

    bavg_pkg::state_t state_reg, state_next;

    logic [bavg_pkg::WCFG_W-1:0]  image_width_reg;
    logic [bavg_pkg::HGT_W-1:0]   image_height_reg;
    logic [bavg_pkg::BLK_W-1:0]   block_size_reg;

    logic [COL_W-1:0]             pixel_column_reg;
    logic [bavg_pkg::ROW_W-1:0]   pixel_row_reg;
    logic [bavg_pkg::TILE_W-1:0]  column_in_tile_reg;
    logic [bavg_pkg::TILE_W-1:0]  row_in_tile_reg;
    logic [COL_W-1:0]             tile_column_reg;

    logic [bavg_pkg::PIX_W-1:0]   pix_reg;
    logic [COL_W-1:0]             slot_reg;
    logic                         first_reg;
    logic                         tile_end_reg;
    logic                         line_end_reg;
    logic                         frame_end_reg;
    logic [bavg_pkg::NPIX_W-1:0]  npix_reg;
    logic [bavg_pkg::PROD_W-1:0]  prod_reg;
    logic [bavg_pkg::CHAR_W-1:0]  char_reg;

    logic [W_W-1:0]               w_clamp;
    logic [bavg_pkg::HGT_W-1:0]   h_clamp;
    logic [bavg_pkg::BLK_W-1:0]   bs_clamp;
    logic                         last_col;
    logic                         last_row;
    logic                         col_wrap;
    logic                         row_wrap;
    logic                         s_fire;
    logic                         cfg_fire;

    logic [bavg_pkg::SUM_W-1:0]   rd_data;
    logic [bavg_pkg::SUM_W-1:0]   sum;
    logic                         div_start;
    logic [bavg_pkg::SUM_W-1:0]   quotient;
    bavg_pkg::div_status_t        div_status;
    logic [bavg_pkg::PIX_W-1:0]   mean;
    logic [bavg_pkg::PROD_W+1:0]  idx_wide;
    logic [bavg_pkg::IDX_W-1:0]   idx;
    logic [13:0]                  npix_wide;

    // register clamping
    always_comb begin
        if (image_width_reg == '0) begin
            w_clamp = W_W'(1);
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            w_clamp = W_W'(MAX_WIDTH);
        end else begin
            w_clamp = W_W'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_clamp = bavg_pkg::HGT_W'(1);
        end else if (32'(image_height_reg) > bavg_pkg::MAX_HEIGHT) begin
            h_clamp = bavg_pkg::HGT_W'(bavg_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = image_height_reg;
        end
        if (block_size_reg == '0) begin
            bs_clamp = bavg_pkg::BLK_W'(1);
        end else if (32'(block_size_reg) > bavg_pkg::MAX_BLOCK) begin
            bs_clamp = bavg_pkg::BLK_W'(bavg_pkg::MAX_BLOCK);
        end else begin
            bs_clamp = block_size_reg;
        end
    end

    assign last_col  = (32'(pixel_column_reg) + 1) >= 32'(w_clamp);
    assign last_row  = (32'(pixel_row_reg) + 1) >= 32'(h_clamp);
    assign col_wrap  = ({1'b0, column_in_tile_reg} + 1'b1) >= bs_clamp;
    assign row_wrap  = ({1'b0, row_in_tile_reg} + 1'b1) >= bs_clamp;
    assign npix_wide = ({1'b0, column_in_tile_reg} + 7'd1) * ({1'b0, row_in_tile_reg} + 7'd1);

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign s_ready   = (state_reg == bavg_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        if (first_reg) begin
            sum = bavg_pkg::SUM_W'(pix_reg);
        end else begin
            sum = rd_data + bavg_pkg::SUM_W'(pix_reg);
        end
    end

    assign div_start = (state_reg == bavg_pkg::ST_ACC) && tile_end_reg;

    assign mean = (quotient > bavg_pkg::SUM_W'(bavg_pkg::FULL_SCALE)) ?
                  bavg_pkg::PIX_W'(bavg_pkg::FULL_SCALE) : quotient[bavg_pkg::PIX_W-1:0];

    // x/255 as (x + (x >> 8) + 1) >> 8, exact for the product range
    assign idx_wide = ({2'b00, prod_reg} + {10'd0, prod_reg[bavg_pkg::PROD_W-1:8]} + 1'b1) >> 8;
    assign idx = (idx_wide > (bavg_pkg::PROD_W+2)'(bavg_pkg::RAMP_LENGTH - 1)) ?
                 bavg_pkg::IDX_W'(bavg_pkg::RAMP_LENGTH - 1) : idx_wide[bavg_pkg::IDX_W-1:0];

    bavg_sum_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (tile_column_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == bavg_pkg::ST_ACC),
        .wr_addr (slot_reg),
        .wr_data (sum)
    );

    bavg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum),
        .divisor  (npix_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bavg_pkg::ST_IDLE: if (s_fire) state_next = bavg_pkg::ST_ACC;
            bavg_pkg::ST_ACC:  state_next = tile_end_reg ? bavg_pkg::ST_DIV : bavg_pkg::ST_IDLE;
            bavg_pkg::ST_DIV:  if (div_status.done) state_next = bavg_pkg::ST_IDX;
            bavg_pkg::ST_IDX:  state_next = bavg_pkg::ST_OUT1;
            bavg_pkg::ST_OUT1: if (m_ready) state_next = bavg_pkg::ST_OUT2;
            bavg_pkg::ST_OUT2: if (m_ready) state_next = bavg_pkg::ST_IDLE;
            default:           state_next = bavg_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        m_valid       = (state_reg == bavg_pkg::ST_OUT1) || (state_reg == bavg_pkg::ST_OUT2);
        m_second_copy = (state_reg == bavg_pkg::ST_OUT2);
        m_line_end    = (state_reg == bavg_pkg::ST_OUT2) && line_end_reg;
        m_frame_end   = (state_reg == bavg_pkg::ST_OUT2) && frame_end_reg;
        m_char_code   = char_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= bavg_pkg::ST_IDLE;
            image_width_reg    <= bavg_pkg::WCFG_W'(640);
            image_height_reg   <= bavg_pkg::HGT_W'(480);
            block_size_reg     <= bavg_pkg::BLK_W'(8);
            pixel_column_reg   <= '0;
            pixel_row_reg      <= '0;
            column_in_tile_reg <= '0;
            row_in_tile_reg    <= '0;
            tile_column_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                if (cfg_addr == bavg_pkg::REG_IMAGE_WIDTH ||
                    cfg_addr == bavg_pkg::REG_IMAGE_HEIGHT ||
                    cfg_addr == bavg_pkg::REG_BLOCK_SIZE) begin
                    pixel_column_reg   <= '0;
                    pixel_row_reg      <= '0;
                    column_in_tile_reg <= '0;
                    row_in_tile_reg    <= '0;
                    tile_column_reg    <= '0;
                end
                unique case (cfg_addr)
                    bavg_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[bavg_pkg::WCFG_W-1:0];
                    bavg_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    bavg_pkg::REG_BLOCK_SIZE:   block_size_reg   <= cfg_data[bavg_pkg::BLK_W-1:0];
                    default: ;
                endcase
            end else if (s_fire) begin
                if (last_col) begin
                    pixel_column_reg   <= '0;
                    column_in_tile_reg <= '0;
                    tile_column_reg    <= '0;
                    if (last_row) begin
                        pixel_row_reg   <= '0;
                        row_in_tile_reg <= '0;
                    end else begin
                        pixel_row_reg   <= pixel_row_reg + 1'b1;
                        row_in_tile_reg <= row_wrap ? '0 : row_in_tile_reg + 1'b1;
                    end
                end else begin
                    pixel_column_reg <= pixel_column_reg + 1'b1;
                    if (col_wrap) begin
                        column_in_tile_reg <= '0;
                        tile_column_reg    <= tile_column_reg + 1'b1;
                    end else begin
                        column_in_tile_reg <= column_in_tile_reg + 1'b1;
                    end
                end
            end
        end
    end

    // per-pixel payload capture, plus the product and ramp character registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pix_reg       <= s_pixel_value;
            slot_reg      <= tile_column_reg;
            first_reg     <= (column_in_tile_reg == '0) && (row_in_tile_reg == '0);
            tile_end_reg  <= (last_col || col_wrap) && (last_row || row_wrap);
            line_end_reg  <= last_col;
            frame_end_reg <= last_col && last_row;
            npix_reg      <= npix_wide[bavg_pkg::NPIX_W-1:0];
        end
        if (state_reg == bavg_pkg::ST_DIV && div_status.done) begin
            prod_reg <= bavg_pkg::PROD_W'(mean * (bavg_pkg::RAMP_LENGTH - 1));
        end
        if (state_reg == bavg_pkg::ST_IDX) begin
            char_reg <= bavg_pkg::ramp_char(idx);
        end
    end

endmodule
